// ===== rtl/mlr_pkg.sv =====
// shared types, widths and octant move tables for the midpoint line rasterizer
`default_nettype none

package mlr_pkg;

  localparam int unsigned CoordBits    = 12;
  localparam int unsigned DecBits      = CoordBits + 4;
  localparam int unsigned InFieldBits  = 4 * CoordBits;
  localparam int unsigned InDataBits   = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutFieldBits = 2 * CoordBits + 3;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DecBits-1:0]   dec_t;
  typedef logic signed [1:0]           move_t;

  typedef enum logic {
    CmdLoad = 1'b0,
    CmdStep = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    Zone0 = 3'd0,
    Zone1 = 3'd1,
    Zone2 = 3'd2,
    Zone3 = 3'd3,
    Zone4 = 3'd4,
    Zone5 = 3'd5,
    Zone6 = 3'd6,
    Zone7 = 3'd7
  } zone_e;

  localparam move_t MoveFwd  = 2'sb01;
  localparam move_t MoveNone = 2'sb00;
  localparam move_t MoveBack = 2'sb11;

  typedef struct packed {
    cmd_e   cmd;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_item_t;

  typedef struct packed {
    zone_e  zone;
    dec_t   d0;
    dec_t   inc_neg;
    dec_t   inc_pos;
    coord_t end_major;
  } setup_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    zone_e  octant;
    logic   last;
  } pix_t;

  // moves taken while the decision is negative
  function automatic move_t move_neg_x(zone_e z);
    move_t m;
    unique case (z)
      Zone0, Zone1, Zone7: m = MoveFwd;
      Zone3, Zone4, Zone5: m = MoveBack;
      default:             m = MoveNone;
    endcase
    return m;
  endfunction

  function automatic move_t move_neg_y(zone_e z);
    move_t m;
    unique case (z)
      Zone1, Zone2, Zone3: m = MoveFwd;
      Zone5, Zone6, Zone7: m = MoveBack;
      default:             m = MoveNone;
    endcase
    return m;
  endfunction

  // moves taken while the decision is zero or positive
  function automatic move_t move_pos_x(zone_e z);
    move_t m;
    unique case (z)
      Zone0, Zone6, Zone7: m = MoveFwd;
      Zone2, Zone3, Zone4: m = MoveBack;
      default:             m = MoveNone;
    endcase
    return m;
  endfunction

  function automatic move_t move_pos_y(zone_e z);
    move_t m;
    unique case (z)
      Zone0, Zone1, Zone2: m = MoveFwd;
      Zone4, Zone5, Zone6: m = MoveBack;
      default:             m = MoveNone;
    endcase
    return m;
  endfunction

  // one unit step with saturation at the coordinate range
  function automatic coord_t step_coord(coord_t c, move_t m);
    logic signed [CoordBits:0] s;
    coord_t r;
    s = {c[CoordBits-1], c} + {{(CoordBits - 1){m[1]}}, m};
    if (s[CoordBits] != s[CoordBits-1]) begin
      r = s[CoordBits] ? {1'b1, {(CoordBits - 1){1'b0}}} : {1'b0, {(CoordBits - 1){1'b1}}};
    end else begin
      r = s[CoordBits-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mlr_setup.sv =====
// line setup: octant choice, initial decision and both increments
`default_nettype none

module mlr_setup
  import mlr_pkg::*;
(
  input  in_item_t item_i,
  output setup_t   setup_o
);

  logic signed [CoordBits:0] dx_n, dy_n;
  dec_t  dx, dy, dx2, dy2;
  zone_e zone;

  always_comb begin
    dx_n = {item_i.x_end[CoordBits-1], item_i.x_end}
         - {item_i.x_start[CoordBits-1], item_i.x_start};
    dy_n = {item_i.y_end[CoordBits-1], item_i.y_end}
         - {item_i.y_start[CoordBits-1], item_i.y_start};
    dx  = {{(DecBits - CoordBits - 1){dx_n[CoordBits]}}, dx_n};
    dy  = {{(DecBits - CoordBits - 1){dy_n[CoordBits]}}, dy_n};
    dx2 = dx <<< 1;
    dy2 = dy <<< 1;

    // ties fall to the steeper zone
    if (!dx[DecBits-1] && !dy[DecBits-1]) begin
      zone = (dx > dy) ? Zone0 : Zone1;
    end else if (!dx[DecBits-1]) begin
      zone = (dx > -dy) ? Zone7 : Zone6;
    end else if (!dy[DecBits-1]) begin
      zone = (-dx > dy) ? Zone3 : Zone2;
    end else begin
      zone = (dx < dy) ? Zone4 : Zone5;
    end

    setup_o.zone = zone;
    unique case (zone)
      Zone0: begin
        setup_o.d0 = dy2 - dx;  setup_o.inc_neg = dy2;        setup_o.inc_pos = dy2 - dx2;
      end
      Zone1: begin
        setup_o.d0 = dy - dx2;  setup_o.inc_neg = dy2 - dx2;  setup_o.inc_pos = -dx2;
      end
      Zone2: begin
        setup_o.d0 = -dy - dx2; setup_o.inc_neg = -dx2;       setup_o.inc_pos = -dy2 - dx2;
      end
      Zone3: begin
        setup_o.d0 = -dy2 - dx; setup_o.inc_neg = -dx2 - dy2; setup_o.inc_pos = -dy2;
      end
      Zone4: begin
        setup_o.d0 = dx - dy2;  setup_o.inc_neg = -dy2;       setup_o.inc_pos = dx2 - dy2;
      end
      Zone5: begin
        setup_o.d0 = dx2 - dy;  setup_o.inc_neg = dx2 - dy2;  setup_o.inc_pos = dx2;
      end
      Zone6: begin
        setup_o.d0 = dx2 + dy;  setup_o.inc_neg = dx2;        setup_o.inc_pos = dx2 + dy2;
      end
      default: begin
        setup_o.d0 = dy2 + dx;  setup_o.inc_neg = dx2 + dy2;  setup_o.inc_pos = dy2;
      end
    endcase

    case (zone) inside
      Zone0, Zone3, Zone4, Zone7: setup_o.end_major = item_i.x_end;
      default:                    setup_o.end_major = item_i.y_end;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mlr_core.sv =====
// line state registers and the combinational midpoint step
`default_nettype none

module mlr_core
  import mlr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  in_item_t item_i,
  output logic     busy_o,
  output pix_t     pix_o
);

  setup_t setup;

  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d, end_major_q, end_major_d;
  dec_t   decision_q, decision_d, inc_neg_q, inc_neg_d, inc_pos_q, inc_pos_d;
  zone_e  zone_q, zone_d;
  logic   busy_q, busy_d;

  coord_t nx, ny;
  dec_t   dec_next;
  logic   dneg, more;

  mlr_setup u_setup (
    .item_i  (item_i),
    .setup_o (setup)
  );

  always_comb begin
    dneg = decision_q[DecBits-1];
    if (dneg) begin
      nx       = step_coord(cur_x_q, move_neg_x(zone_q));
      ny       = step_coord(cur_y_q, move_neg_y(zone_q));
      dec_next = decision_q + inc_neg_q;
    end else begin
      nx       = step_coord(cur_x_q, move_pos_x(zone_q));
      ny       = step_coord(cur_y_q, move_pos_y(zone_q));
      dec_next = decision_q + inc_pos_q;
    end

    case (zone_q) inside
      Zone0, Zone7: more = nx < end_major_q;
      Zone3, Zone4: more = nx > end_major_q;
      Zone1, Zone2: more = ny < end_major_q;
      default:      more = ny > end_major_q;
    endcase

    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    decision_d  = decision_q;
    inc_neg_d   = inc_neg_q;
    inc_pos_d   = inc_pos_q;
    end_major_d = end_major_q;
    zone_d      = zone_q;
    busy_d      = busy_q;

    if (advance_i) begin
      if (item_i.cmd == CmdLoad) begin
        cur_x_d     = item_i.x_start;
        cur_y_d     = item_i.y_start;
        decision_d  = setup.d0;
        inc_neg_d   = setup.inc_neg;
        inc_pos_d   = setup.inc_pos;
        end_major_d = setup.end_major;
        zone_d      = setup.zone;
        busy_d      = 1'b1;
      end else if (busy_q) begin
        cur_x_d    = nx;
        cur_y_d    = ny;
        decision_d = dec_next;
        busy_d     = more;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      decision_q  <= '0;
      inc_neg_q   <= '0;
      inc_pos_q   <= '0;
      end_major_q <= '0;
      zone_q      <= Zone0;
      busy_q      <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      decision_q  <= decision_d;
      inc_neg_q   <= inc_neg_d;
      inc_pos_q   <= inc_pos_d;
      end_major_q <= end_major_d;
      zone_q      <= zone_d;
      busy_q      <= busy_d;
    end
  end

  assign busy_o       = busy_q;
  assign pix_o.x      = cur_x_q;
  assign pix_o.y      = cur_y_q;
  assign pix_o.octant = zone_q;
  assign pix_o.last   = !more;

endmodule

`default_nettype wire

// ===== rtl/midpoint_line_rasterizer_top.sv =====
// top level of the eight-octant midpoint line rasterizer
//
//  channel  dir  tdata (lsb first)                        side bits
//  s_axis   in   x_start, y_start, x_end, y_end            tuser = cmd (0 load, 1 step)
//  m_axis   out  pixel_x, pixel_y, octant, zero pad        tlast = last pixel of line
//
// an input beat lands in the input register; from there it is either a load
// (sets up the line, no output) or a step (one pixel into the output register)
// one beat per clock sustained while the output is not stalled;
// the decision add plus the saturating step and end compare set the cycle
// a stalled output beat holds; the input register still drains loads and idle steps
// reset leaves the block idle with no line loaded
`default_nettype none

module midpoint_line_rasterizer_top
  import mlr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [InDataBits-1:0]  s_axis_tdata,   // x_start, y_start, x_end, y_end
  input  logic                   s_axis_tuser,   // cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OutDataBits-1:0] m_axis_tdata,   // pixel_x, pixel_y, octant
  output logic                   m_axis_tlast    // last
);

  logic     in_valid_q, in_valid_d;
  in_item_t in_item_q, in_item_d;
  logic     out_valid_q, out_valid_d;
  pix_t     out_pix_q, out_pix_d;

  logic     busy, produces, out_free, advance;
  pix_t     pix;

  mlr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .busy_o    (busy),
    .pix_o     (pix)
  );

  always_comb begin
    produces      = (in_item_q.cmd == CmdStep) && busy;
    out_free      = !out_valid_q || m_axis_tready;
    advance       = in_valid_q && (!produces || out_free);
    s_axis_tready = !in_valid_q || advance;

    in_valid_d = in_valid_q;
    in_item_d  = in_item_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d        = 1'b1;
      in_item_d.cmd     = cmd_e'(s_axis_tuser);
      in_item_d.x_start = s_axis_tdata[CoordBits-1:0];
      in_item_d.y_start = s_axis_tdata[2*CoordBits-1:CoordBits];
      in_item_d.x_end   = s_axis_tdata[3*CoordBits-1:2*CoordBits];
      in_item_d.y_end   = s_axis_tdata[4*CoordBits-1:3*CoordBits];
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    if (advance && produces) begin
      out_valid_d = 1'b1;
      out_pix_d   = pix;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_item_q <= in_item_d;
    out_pix_q <= out_pix_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataBits - OutFieldBits){1'b0}},
                          out_pix_q.octant, out_pix_q.y, out_pix_q.x};
  assign m_axis_tlast  = out_pix_q.last;

endmodule

`default_nettype wire

// ===== rtl/mlr_checker.sv =====
// port-level checks for the rasterizer top level, bound in below
`default_nettype none

module mlr_checker
  import mlr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [InDataBits-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OutDataBits-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // input side never backs up while the output side can drain
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with output free");

  // pad bits above the octant stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutDataBits-1:OutFieldBits] == '0)
    else $error("output pad bits set");

  // nothing comes out straight out of reset
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind midpoint_line_rasterizer_top mlr_checker u_mlr_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the midpoint line rasterizer, with scoreboard and stream drivers
`timescale 1ns / 100ps

module tb_top;
  import mlr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 20;

  // predicts the pixel stream and holds the pixels still owed by the block
  class raster_scoreboard;
    coord_t   pos_x, pos_y;
    dec_t     dvar, step_neg, step_pos;
    coord_t   major_end;
    zone_e    line_zone;
    bit       drawing;
    pix_t     pending[$];
    int       errors, pixels, lines;
    bit [7:0] zones_seen;

    function new();
      pos_x = '0;
      pos_y = '0;
      dvar = '0;
      step_neg = '0;
      step_pos = '0;
      major_end = '0;
      line_zone = Zone0;
      drawing = 1'b0;
      errors = 0;
      pixels = 0;
      lines = 0;
      zones_seen = '0;
    endfunction

    static function int sat_coord(int v);
      int hi, lo;
      hi = (1 << (CoordBits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    static function int coord_field(logic [InDataBits-1:0] data, int idx);
      coord_t c;
      c = data[idx*CoordBits +: CoordBits];
      return int'(c);
    endfunction

    // unit move of each zone for a negative or a non-negative decision
    static function void zone_moves(zone_e z, bit neg, output int mx, output int my);
      mx = 0;
      my = 0;
      if (neg) begin
        case (z)
          Zone0, Zone1, Zone7: mx = 1;
          Zone3, Zone4, Zone5: mx = -1;
          default:             mx = 0;
        endcase
        case (z)
          Zone1, Zone2, Zone3: my = 1;
          Zone5, Zone6, Zone7: my = -1;
          default:             my = 0;
        endcase
      end else begin
        case (z)
          Zone0, Zone6, Zone7: mx = 1;
          Zone2, Zone3, Zone4: mx = -1;
          default:             mx = 0;
        endcase
        case (z)
          Zone0, Zone1, Zone2: my = 1;
          Zone4, Zone5, Zone6: my = -1;
          default:             my = 0;
        endcase
      end
    endfunction

    function void note_beat(cmd_e cmd, logic [InDataBits-1:0] data);
      int   xs, ys, xe, ye, dx, dy, d0, dn, dp, mx, my;
      bit   neg, more;
      pix_t p;
      if (cmd == CmdLoad) begin
        xs = coord_field(data, 0);
        ys = coord_field(data, 1);
        xe = coord_field(data, 2);
        ye = coord_field(data, 3);
        dx = xe - xs;
        dy = ye - ys;
        if (dx >= 0 && dy >= 0) line_zone = (dx > dy) ? Zone0 : Zone1;
        else if (dx >= 0)       line_zone = (dx > -dy) ? Zone7 : Zone6;
        else if (dy >= 0)       line_zone = (-dx > dy) ? Zone3 : Zone2;
        else                    line_zone = (dx < dy) ? Zone4 : Zone5;
        case (line_zone)
          Zone0: begin d0 = 2 * dy - dx;  dn = 2 * dy;         dp = 2 * (dy - dx); end
          Zone1: begin d0 = dy - 2 * dx;  dn = 2 * (dy - dx);  dp = -2 * dx;       end
          Zone2: begin d0 = -dy - 2 * dx; dn = -2 * dx;        dp = -2 * (dy + dx); end
          Zone3: begin d0 = -2 * dy - dx; dn = -2 * (dx + dy); dp = -2 * dy;       end
          Zone4: begin d0 = dx - 2 * dy;  dn = -2 * dy;        dp = 2 * (dx - dy); end
          Zone5: begin d0 = 2 * dx - dy;  dn = 2 * (dx - dy);  dp = 2 * dx;        end
          Zone6: begin d0 = 2 * dx + dy;  dn = 2 * dx;         dp = 2 * (dx + dy); end
          default: begin d0 = 2 * dy + dx; dn = 2 * (dx + dy); dp = 2 * dy;        end
        endcase
        dvar = dec_t'(d0);
        step_neg = dec_t'(dn);
        step_pos = dec_t'(dp);
        case (line_zone)
          Zone0, Zone3, Zone4, Zone7: major_end = coord_t'(xe);
          default:                    major_end = coord_t'(ye);
        endcase
        pos_x = coord_t'(xs);
        pos_y = coord_t'(ys);
        drawing = 1'b1;
        lines++;
        zones_seen[line_zone] = 1'b1;
        return;
      end
      // a step with no line in progress is dropped
      if (!drawing) return;
      p.x = pos_x;
      p.y = pos_y;
      p.octant = line_zone;
      neg = (dvar < 0);
      zone_moves(line_zone, neg, mx, my);
      pos_x = coord_t'(sat_coord(int'(pos_x) + mx));
      pos_y = coord_t'(sat_coord(int'(pos_y) + my));
      dvar = neg ? dvar + step_neg : dvar + step_pos;
      case (line_zone)
        Zone0, Zone7: more = (pos_x < major_end);
        Zone3, Zone4: more = (pos_x > major_end);
        Zone1, Zone2: more = (pos_y < major_end);
        default:      more = (pos_y > major_end);
      endcase
      drawing = more;
      p.last = !more;
      pending.push_back(p);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_beat(logic [OutDataBits-1:0] data, logic lst);
      pix_t   e;
      coord_t gx, gy;
      zone_e  gz;
      gx = data[0 +: CoordBits];
      gy = data[CoordBits +: CoordBits];
      gz = zone_e'(data[2*CoordBits +: 3]);
      if (pending.size() == 0) begin
        report($sformatf("unexpected pixel x=%0d y=%0d octant=%0d last=%b", gx, gy, gz, lst));
        return;
      end
      e = pending.pop_front();
      pixels++;
      if (gx !== e.x) report($sformatf("pixel_x %0d, expected %0d", gx, e.x));
      if (gy !== e.y) report($sformatf("pixel_y %0d, expected %0d", gy, e.y));
      if (gz !== e.octant) report($sformatf("octant %0d, expected %0d", gz, e.octant));
      if (lst !== e.last) report($sformatf("last %b, expected %b at (%0d,%0d)", lst, e.last, e.x,
                                           e.y));
      if (data[OutDataBits-1:OutFieldBits] !== '0) report("tdata padding not zero");
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  raster_scoreboard sb = new();
  int  cycles = 0;
  int  n_sent = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  midpoint_line_rasterizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels still owed", cycles, sb.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // input beats are predicted before output beats are checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_beat(cmd_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tlast);
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 21);
      end
    end
  end

  task automatic send_beat(cmd_e cmd, logic [InDataBits-1:0] data);
    logic [63:0] junk;
    while (idle_on && $urandom_range(0, 99) < 21) begin
      junk = {$urandom, $urandom};
      s_axis_tvalid <= 1'b0;
      s_axis_tuser <= junk[63];
      s_axis_tdata <= junk[InDataBits-1:0];
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    @(negedge clk_i);
    n_sent++;
  endtask

  task automatic send_step();
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    send_beat(CmdStep, junk[InDataBits-1:0]);
  endtask

  task automatic draw_line(int xs, int ys, int xe, int ye, int steps);
    logic [InDataBits-1:0] d;
    d = '0;
    d[0*CoordBits +: CoordBits] = xs[CoordBits-1:0];
    d[1*CoordBits +: CoordBits] = ys[CoordBits-1:0];
    d[2*CoordBits +: CoordBits] = xe[CoordBits-1:0];
    d[3*CoordBits +: CoordBits] = ye[CoordBits-1:0];
    send_beat(CmdLoad, d);
    repeat (steps) send_step();
  endtask

  initial begin
    int xs, ys, xe, ye, dx, dy, major, steps, pick, span, tweak;
    bit pressed;
    pressed = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: idle steps, zero length, every zone at the coordinate extremes with ties
    send_step();
    draw_line(5, -7, 5, -7, 2);
    draw_line(-2048, 0, 2047, 100, 1);
    draw_line(-2048, -2048, 2047, 2047, 2);
    draw_line(2047, -2048, -2048, 2047, 1);
    draw_line(2047, 0, -2048, 10, 1);
    draw_line(2047, 2047, -2048, 2000, 1);
    draw_line(2047, 2047, -2048, -2048, 1);
    draw_line(-2048, 2047, 2047, -2048, 1);
    draw_line(-2048, -1, 2047, -2048, 1);
    draw_line(0, 0, -1, 0, 1);
    send_step();

    while (n_sent < 900) begin
      idle_on = !(n_sent >= 450 && n_sent < 650);
      if (!pressed && n_sent >= 300) begin
        // long output hold-off while steps keep coming, so the input backs up
        pressed = 1'b1;
        hold_req = 1'b1;
        draw_line(-30, 17, 30, 40, 60);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          span = ($urandom_range(0, 99) < 4) ? 200 : 12;
          xs = $urandom_range(0, 4095) - 2048;
          ys = $urandom_range(0, 4095) - 2048;
          xe = raster_scoreboard::sat_coord(xs + $urandom_range(0, 2 * span) - span);
          ye = raster_scoreboard::sat_coord(ys + $urandom_range(0, 2 * span) - span);
          dx = (xe > xs) ? xe - xs : xs - xe;
          dy = (ye > ys) ? ye - ys : ys - ye;
          major = (dx > dy) ? dx : dy;
          if (major == 0) major = 1;
          tweak = $urandom_range(0, 99);
          if (tweak < 8) steps = $urandom_range(0, major - 1);
          else if (tweak < 16) steps = major + $urandom_range(1, 2);
          else steps = major;
          draw_line(xs, ys, xe, ye, steps);
        end else if (pick < 90) begin
          send_step();
        end else begin
          draw_line($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                    $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                    $urandom_range(0, 5));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    idle_on = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d input beats over %0d lines, %0d pixels compared, octants hit %b",
             n_sent, sb.lines, sb.pixels, sb.zones_seen);
    $display("covered idle steps, loads over unfinished lines and one long output hold-off");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mlr_pkg.sv
rtl/mlr_setup.sv
rtl/mlr_core.sv
rtl/midpoint_line_rasterizer_top.sv
rtl/mlr_checker.sv
tb/tb_top.sv
